[rtl/overcurrent_fault_monitor_assert.svh]
// Assertion macros for the over-current fault monitor checker.
// Both sample on aclk and stand down while aresetn is low.
`ifndef OVERCURRENT_FAULT_MONITOR_ASSERT_SVH
`define OVERCURRENT_FAULT_MONITOR_ASSERT_SVH

// Same-cycle implication.
`define OCFM_CHECK(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("overcurrent_fault_monitor: check failed");

// Next-cycle implication.
`define OCFM_CHECK_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("overcurrent_fault_monitor: check failed");

`endif

[rtl/ocfm_pkg.sv]
package ocfm_pkg;

    typedef enum logic [2:0] {
        MODE_OFF     = 3'd0,
        MODE_NORMAL  = 3'd1,
        MODE_FILTER  = 3'd2,
        MODE_FAULT   = 3'd3,
        MODE_INHIBIT = 3'd4
    } mode_t;

    localparam logic [1:0] STATUS_OFF      = 2'd0;
    localparam logic [1:0] STATUS_CHARGING = 2'd1;

    localparam int THRESHOLD_BITS = 16;
    localparam int TICKS_BITS     = 16;
    localparam int COUNT_BITS     = 8;
    localparam int DATA_BITS      = 32;
    localparam int ADDR_BITS      = 4;
    localparam int REG_IDX_BITS   = 2;

    localparam logic [REG_IDX_BITS-1:0] REG_THRESHOLD    = 2'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_FILTER_TICKS = 2'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_RETRY_TICKS  = 2'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_FAULT_LIMIT  = 2'd3;

    localparam logic [THRESHOLD_BITS-1:0] THRESHOLD_RESET    = 16'd65535;
    localparam logic [TICKS_BITS-1:0]     FILTER_TICKS_RESET = 16'd10;
    localparam logic [TICKS_BITS-1:0]     RETRY_TICKS_RESET  = 16'd100;
    localparam logic [COUNT_BITS-1:0]     FAULT_LIMIT_RESET  = 8'd3;

    typedef struct packed {
        logic [THRESHOLD_BITS-1:0] current_threshold;
        logic [TICKS_BITS-1:0]     filter_ticks;
        logic [TICKS_BITS-1:0]     retry_ticks;
        logic [COUNT_BITS-1:0]     fault_limit;
    } cfg_t;

    typedef struct packed {
        logic  fault_flag;
        mode_t mode;
    } result_t;

endpackage

[rtl/ocfm_regs.sv]
module ocfm_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ocfm_pkg::ADDR_BITS-1:0]      paddr,
    input  logic [ocfm_pkg::DATA_BITS-1:0]      pwdata,
    output logic [ocfm_pkg::DATA_BITS-1:0]      prdata,
    output ocfm_pkg::cfg_t                      cfg
);

    ocfm_pkg::cfg_t                        cfg_reg;
    ocfm_pkg::cfg_t                        cfg_next;
    logic [ocfm_pkg::REG_IDX_BITS-1:0]     reg_idx;
    logic                                  wr_en;

    assign reg_idx = paddr[ocfm_pkg::REG_IDX_BITS+1:2];
    assign wr_en   = psel && penable && pwrite;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            case (reg_idx)
                ocfm_pkg::REG_THRESHOLD:
                    cfg_next.current_threshold = pwdata[ocfm_pkg::THRESHOLD_BITS-1:0];
                ocfm_pkg::REG_FILTER_TICKS:
                    cfg_next.filter_ticks = pwdata[ocfm_pkg::TICKS_BITS-1:0];
                ocfm_pkg::REG_RETRY_TICKS:
                    cfg_next.retry_ticks = pwdata[ocfm_pkg::TICKS_BITS-1:0];
                ocfm_pkg::REG_FAULT_LIMIT:
                    cfg_next.fault_limit = pwdata[ocfm_pkg::COUNT_BITS-1:0];
                default: begin
                    cfg_next = cfg_reg;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.current_threshold <= ocfm_pkg::THRESHOLD_RESET;
            cfg_reg.filter_ticks      <= ocfm_pkg::FILTER_TICKS_RESET;
            cfg_reg.retry_ticks       <= ocfm_pkg::RETRY_TICKS_RESET;
            cfg_reg.fault_limit       <= ocfm_pkg::FAULT_LIMIT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // Zero-extend the selected register onto the read bus.
    always_comb begin
        case (reg_idx)
            ocfm_pkg::REG_THRESHOLD:
                prdata = ocfm_pkg::DATA_BITS'(cfg_reg.current_threshold);
            ocfm_pkg::REG_FILTER_TICKS:
                prdata = ocfm_pkg::DATA_BITS'(cfg_reg.filter_ticks);
            ocfm_pkg::REG_RETRY_TICKS:
                prdata = ocfm_pkg::DATA_BITS'(cfg_reg.retry_ticks);
            ocfm_pkg::REG_FAULT_LIMIT:
                prdata = ocfm_pkg::DATA_BITS'(cfg_reg.fault_limit);
            default: begin
                prdata = '0;
            end
        endcase
    end

    assign cfg = cfg_reg;

endmodule

[rtl/ocfm_core.sv]
module ocfm_core #(
    parameter int TIMER_BITS  = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   advance,
    input  logic [1:0]             status,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  ocfm_pkg::cfg_t         cfg,
    output ocfm_pkg::result_t      result
);

    localparam int CMP_BITS =
        (SAMPLE_BITS > ocfm_pkg::THRESHOLD_BITS) ? SAMPLE_BITS : ocfm_pkg::THRESHOLD_BITS;
    localparam int TCMP_BITS =
        (TIMER_BITS > ocfm_pkg::TICKS_BITS) ? TIMER_BITS : ocfm_pkg::TICKS_BITS;

    logic                               started_reg;
    ocfm_pkg::mode_t                    mode_reg;
    ocfm_pkg::mode_t                    mode_next;
    logic [ocfm_pkg::COUNT_BITS-1:0]    fault_count_reg;
    logic [ocfm_pkg::COUNT_BITS-1:0]    fault_count_next;
    logic [TIMER_BITS-1:0]              filter_timer_reg;
    logic [TIMER_BITS-1:0]              filter_timer_next;
    logic [TIMER_BITS-1:0]              retry_timer_reg;
    logic [TIMER_BITS-1:0]              retry_timer_next;

    logic                               over;
    logic [TIMER_BITS-1:0]              filter_adv;
    logic [TIMER_BITS-1:0]              retry_adv;
    logic                               filter_done;
    logic                               retry_done;
    logic                               below_limit;
    logic [ocfm_pkg::COUNT_BITS-1:0]    count_inc;
    logic                               fired;

    assign over = CMP_BITS'(sample) >= CMP_BITS'(cfg.current_threshold);

    // Running timers advance first and saturate at all ones.
    assign filter_adv = (mode_reg == ocfm_pkg::MODE_FILTER && filter_timer_reg != '1)
                      ? filter_timer_reg + TIMER_BITS'(1) : filter_timer_reg;
    assign retry_adv  = (mode_reg == ocfm_pkg::MODE_FAULT && retry_timer_reg != '1)
                      ? retry_timer_reg + TIMER_BITS'(1) : retry_timer_reg;

    assign filter_done = TCMP_BITS'(filter_adv) >= TCMP_BITS'(cfg.filter_ticks);
    assign retry_done  = TCMP_BITS'(retry_adv) >= TCMP_BITS'(cfg.retry_ticks);
    assign below_limit = fault_count_reg < cfg.fault_limit;
    assign count_inc   = (fault_count_reg != '1)
                       ? fault_count_reg + ocfm_pkg::COUNT_BITS'(1) : fault_count_reg;

    always_comb begin
        mode_next         = mode_reg;
        fault_count_next  = fault_count_reg;
        filter_timer_next = filter_adv;
        retry_timer_next  = retry_adv;
        fired             = 1'b0;

        if (!started_reg) begin
            mode_next         = ocfm_pkg::MODE_OFF;
            fault_count_next  = '0;
            filter_timer_next = '0;
            retry_timer_next  = '0;
        end else begin
            case (mode_reg)
                ocfm_pkg::MODE_OFF: begin
                    if (status == ocfm_pkg::STATUS_CHARGING) begin
                        if (over) begin
                            mode_next         = ocfm_pkg::MODE_FILTER;
                            filter_timer_next = '0;
                        end else begin
                            mode_next        = ocfm_pkg::MODE_NORMAL;
                            fault_count_next = '0;
                        end
                    end
                    // Off already holds everything cleared; fired stays low harmlessly.
                end
                ocfm_pkg::MODE_NORMAL: begin
                    if (over) begin
                        mode_next         = ocfm_pkg::MODE_FILTER;
                        filter_timer_next = '0;
                        fired             = 1'b1;
                    end
                end
                ocfm_pkg::MODE_FILTER: begin
                    if (!over) begin
                        mode_next         = ocfm_pkg::MODE_NORMAL;
                        filter_timer_next = '0;
                        fault_count_next  = '0;
                        fired             = 1'b1;
                    end else if (filter_done) begin
                        mode_next         = ocfm_pkg::MODE_FAULT;
                        filter_timer_next = '0;
                        retry_timer_next  = '0;
                        fault_count_next  = count_inc;
                        fired             = 1'b1;
                    end
                end
                ocfm_pkg::MODE_FAULT, ocfm_pkg::MODE_INHIBIT: begin
                    if (mode_reg == ocfm_pkg::MODE_FAULT && !below_limit) begin
                        mode_next        = ocfm_pkg::MODE_INHIBIT;
                        retry_timer_next = '0;
                        fired            = 1'b1;
                    end else if (below_limit && retry_done) begin
                        retry_timer_next = '0;
                        fired            = 1'b1;
                        if (over) begin
                            mode_next         = ocfm_pkg::MODE_FILTER;
                            filter_timer_next = '0;
                        end else begin
                            mode_next        = ocfm_pkg::MODE_NORMAL;
                            fault_count_next = '0;
                        end
                    end
                end
                default: begin
                    mode_next = ocfm_pkg::MODE_OFF;
                end
            endcase

            // Status off drops any active state back to Off unless a transition fired.
            if (mode_reg != ocfm_pkg::MODE_OFF && !fired
                    && status == ocfm_pkg::STATUS_OFF) begin
                mode_next         = ocfm_pkg::MODE_OFF;
                fault_count_next  = '0;
                filter_timer_next = '0;
                retry_timer_next  = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg      <= 1'b0;
            mode_reg         <= ocfm_pkg::MODE_OFF;
            fault_count_reg  <= '0;
            filter_timer_reg <= '0;
            retry_timer_reg  <= '0;
        end else if (advance) begin
            started_reg      <= 1'b1;
            mode_reg         <= mode_next;
            fault_count_reg  <= fault_count_next;
            filter_timer_reg <= filter_timer_next;
            retry_timer_reg  <= retry_timer_next;
        end
    end

    assign result.mode       = mode_next;
    assign result.fault_flag = (mode_next == ocfm_pkg::MODE_FAULT)
                            || (mode_next == ocfm_pkg::MODE_INHIBIT);

endmodule

[rtl/overcurrent_fault_monitor.sv]
// Channel   Direction  Ports                                       Meaning
// s_        in         s_valid s_ready s_charger_status             one tick request
//                      s_current_sample
// m_        out        m_valid m_ready m_fault_flag m_monitor_state one result per tick
// apb       in/out     psel penable pwrite paddr pwdata prdata      threshold, timers,
//                      pready                                       fault limit
//
// Cycles: one request per cycle sustained unless a held result stalls; a taken request
//   loads the input register, and an advance loads its result into the result register.
// The monitor state update is one compare-and-select step between the two
//   registers.
// Reset: synchronous on aresetn low; pipeline empty, machine not yet started,
//   registers at their reset values.
// Stalls: a held result keeps one request parked in the input register;
//   s_ready drops only when both stages are full and m_ready is low.
module overcurrent_fault_monitor #(
    parameter int TIMER_BITS  = 16,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,

    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [1:0]                          s_charger_status,
    input  logic [SAMPLE_BITS-1:0]              s_current_sample,

    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_fault_flag,
    output logic [2:0]                          m_monitor_state,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [ocfm_pkg::ADDR_BITS-1:0]      paddr,
    input  logic [ocfm_pkg::DATA_BITS-1:0]      pwdata,
    output logic [ocfm_pkg::DATA_BITS-1:0]      prdata,
    output logic                                pready
);

    ocfm_pkg::cfg_t         cfg;
    ocfm_pkg::result_t      result;

    // Input register: holds one request until the core takes it.
    logic                   in_valid_reg;
    logic                   in_valid_next;
    logic [1:0]             in_status_reg;
    logic [SAMPLE_BITS-1:0] in_sample_reg;

    // Result register: holds one result until the sink takes it.
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   out_fault_flag_reg;
    logic [2:0]             out_state_reg;

    logic                   advance;
    logic                   take;

    // Advance the core when a request is held and the result slot is free or being emptied.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign take    = s_valid && s_ready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (take) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load on their enables, no reset.
    always_ff @(posedge aclk) begin
        if (take) begin
            in_status_reg <= s_charger_status;
            in_sample_reg <= s_current_sample;
        end
        if (advance) begin
            out_fault_flag_reg <= result.fault_flag;
            out_state_reg      <= result.mode;
        end
    end

    ocfm_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    ocfm_core #(
        .TIMER_BITS  (TIMER_BITS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .status  (in_status_reg),
        .sample  (in_sample_reg),
        .cfg     (cfg),
        .result  (result)
    );

    assign pready          = 1'b1;
    assign m_valid         = out_valid_reg;
    assign m_fault_flag    = out_fault_flag_reg;
    assign m_monitor_state = out_state_reg;

endmodule

[rtl/ocfm_checker.sv]
`include "overcurrent_fault_monitor_assert.svh"

module ocfm_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       m_valid,
    input logic       m_ready,
    input logic       m_fault_flag,
    input logic [2:0] m_monitor_state
);

    logic       seen_reg;
    logic [2:0] last_state_reg;
    logic       flag_expected;
    logic       in_fault;
    logic       in_inhibit;
    logic       fault_source_ok;
    logic       inhibit_source_ok;

    // Track the state of the last delivered result.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= 1'b0;
        end else if (m_valid && m_ready) begin
            seen_reg <= 1'b1;
        end
        if (m_valid && m_ready) begin
            last_state_reg <= m_monitor_state;
        end
    end

    assign in_fault          = m_monitor_state == ocfm_pkg::MODE_FAULT;
    assign in_inhibit        = m_monitor_state == ocfm_pkg::MODE_INHIBIT;
    assign flag_expected     = in_fault || in_inhibit;
    assign fault_source_ok   = (last_state_reg == ocfm_pkg::MODE_FILTER)
                            || (last_state_reg == ocfm_pkg::MODE_FAULT);
    assign inhibit_source_ok = (last_state_reg == ocfm_pkg::MODE_FAULT)
                            || (last_state_reg == ocfm_pkg::MODE_INHIBIT);

    `OCFM_CHECK(a_flag_matches_state, m_valid, m_fault_flag == flag_expected)

    `OCFM_CHECK(a_fault_from_filter, m_valid && seen_reg && in_fault, fault_source_ok)

    `OCFM_CHECK(a_inhibit_from_fault, m_valid && seen_reg && in_inhibit, inhibit_source_ok)

    `OCFM_CHECK_NEXT(a_result_holds, m_valid && !m_ready, m_valid && $stable(m_monitor_state) && $stable(m_fault_flag))

endmodule

bind overcurrent_fault_monitor ocfm_checker u_ocfm_checker (.*);
